// ----- src/hsv_sat_pkg.sv -----
// Package for the HSV saturation adjust core: payload types and fixed-point constants.
package hsv_sat_pkg;

  localparam int FRAC_BITS = 12;
  localparam int QW        = FRAC_BITS + 1;        // quotient / saturation width
  localparam int HW        = FRAC_BITS + 3;        // hue width, holds 6 << F
  localparam int PW        = FRAC_BITS + 11;       // sat * scale product width
  localparam int CW        = FRAC_BITS + 9;        // vmax * sat width
  localparam int XW        = 2 * FRAC_BITS + 10;   // cq * xf product width

  localparam logic [1:0] MAX_RED   = 2'd0;
  localparam logic [1:0] MAX_GREEN = 2'd1;
  localparam logic [1:0] MAX_BLUE  = 2'd2;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic [9:0] sat_scale;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

endpackage

// ----- src/hsv_saturation_adjust_core.sv -----
// Top level: pipelined RGB -> HSV -> saturation scale -> RGB conversion.
//
//  channel  | handshake     | payload
//  ---------+---------------+-----------------------------
//  input    | start / busy  | item   (pix_in_t)
//  result   | done strobe   | result (pix_out_t)
//
// One pixel per clock. The pipeline is one stage for max/min,
// FRAC_BITS + 1 restoring-division steps (hue and saturation
// quotients side by side), then scale, two multiply stages and the
// output mux. busy is always low. Reset clears only the valid bits.
// The receiver cannot stall, so the pipeline never holds.
module hsv_saturation_adjust_core
  import hsv_sat_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  pix_in_t  item,
  output logic     done,
  output pix_out_t result
);

  typedef struct packed {
    logic [7:0]    vmax;
    logic [7:0]    alpha;
    logic [9:0]    scale;
    logic [1:0]    sel;
    logic          neg;
    logic          dz;     // delta zero
    logic [7:0]    delta;
    logic [7:0]    hrem;
    logic [QW-1:0] hq;
    logic [7:0]    srem;
    logic [QW-1:0] sq;
  } div_t;

  localparam logic [HW-1:0] ONE_H = HW'(1) << FRAC_BITS;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  // entry stage
  div_t          e;
  logic          e_vld;
  // division stages
  div_t          d     [QW];
  logic [QW-1:0] d_vld;
  // post stages
  logic          p1_vld, p2_vld, p3_vld;
  logic [7:0]    p1_vmax, p2_vmax, p3_vmax;
  logic [7:0]    p1_alpha, p2_alpha, p3_alpha;
  logic [2:0]    p1_sector, p2_sector, p3_sector;
  logic [FRAC_BITS-1:0] p1_frac;
  logic [QW-1:0] p1_s2, p2_xf;
  logic [CW-1:0] p2_cq, p3_mq;
  logic [XW-FRAC_BITS-1:0] p3_xq;
  logic [XW-1:0] xprod;

  assign busy = 1'b0;

  // entry: max, min, delta, dominant channel
  logic [7:0] r, g, b, vmax_c, vmin_c;
  always_comb begin
    r = item.red_in;
    g = item.green_in;
    b = item.blue_in;
    vmax_c = (r > g) ? r : g;
    if (b > vmax_c) vmax_c = b;
    vmin_c = (r < g) ? r : g;
    if (b < vmin_c) vmin_c = b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= start;
    end
    e.vmax  <= vmax_c;
    e.alpha <= item.alpha_in;
    e.scale <= item.sat_scale;
    e.delta <= vmax_c - vmin_c;
    e.dz    <= (vmax_c == vmin_c);
    e.hq    <= '0;
    e.sq    <= '0;
    e.srem  <= vmax_c - vmin_c;
    if (vmax_c == r) begin
      e.sel  <= MAX_RED;
      e.neg  <= (g < b);
      e.hrem <= (g >= b) ? g - b : b - g;
    end else if (vmax_c == g) begin
      e.sel  <= MAX_GREEN;
      e.neg  <= (b < r);
      e.hrem <= (b >= r) ? b - r : r - b;
    end else begin
      e.sel  <= MAX_BLUE;
      e.neg  <= (r < g);
      e.hrem <= (r >= g) ? r - g : g - r;
    end
  end

  // restoring division, one quotient bit per stage; numerator <= denominator
  function automatic logic [8:0] div_rs(input logic [7:0] rem, input logic first);
    return first ? {1'b0, rem} : {rem, 1'b0};
  endfunction

  always_ff @(posedge clk) begin
    div_t          src, nxt;
    logic [8:0]    hrs, srs;
    logic          hb, sb;
    if (rst) begin
      d_vld <= '0;
    end else begin
      d_vld <= {d_vld[QW-2:0], e_vld};
    end
    for (int k = 0; k < QW; k++) begin
      src = (k == 0) ? e : d[(k == 0) ? 0 : k - 1];
      hrs = div_rs(src.hrem, k == 0);
      srs = div_rs(src.srem, k == 0);
      hb  = (hrs >= {1'b0, src.delta});
      sb  = (srs >= {1'b0, src.vmax});
      nxt      = src;
      nxt.hq   = {src.hq[QW-2:0], hb};
      nxt.sq   = {src.sq[QW-2:0], sb};
      nxt.hrem = hb ? 8'(hrs - {1'b0, src.delta}) : hrs[7:0];
      nxt.srem = sb ? 8'(srs - {1'b0, src.vmax}) : srs[7:0];
      d[k] <= nxt;
    end
  end

  // hue assembly, saturation scale and clamp
  div_t          dl;
  logic [HW-1:0] base, hue;
  logic [QW-1:0] hqv, sqv;
  logic [PW-1:0] prod;
  logic [PW-9:0] s2w;
  always_comb begin
    dl  = d[QW-1];
    hqv = dl.dz ? '0 : dl.hq;
    sqv = (dl.vmax == 8'd0) ? '0 : dl.sq;
    case (dl.sel)
      MAX_RED:   base = dl.neg ? HW'(6) * ONE_H : '0;
      MAX_GREEN: base = HW'(2) * ONE_H;
      MAX_BLUE:  base = HW'(4) * ONE_H;
      default:   base = '0;
    endcase
    hue = dl.neg ? base - HW'(hqv) : base + HW'(hqv);
    if (hue >= HW'(6) * ONE_H) hue = hue - HW'(6) * ONE_H;
    if (dl.dz) hue = '0;
    prod = PW'(sqv) * PW'(dl.scale);
    s2w  = prod[PW-1:8];
  end

  assign xprod = XW'(p2_cq) * XW'(p2_xf);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      p1_vld <= d_vld[QW-1];
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      done   <= p3_vld;
    end
    p1_vmax   <= dl.vmax;
    p1_alpha  <= dl.alpha;
    p1_sector <= hue[HW-1:FRAC_BITS];
    p1_frac   <= hue[FRAC_BITS-1:0];
    p1_s2     <= (s2w > (PW-8)'(ONE_Q)) ? ONE_Q : s2w[QW-1:0];
    // cq and xf
    p2_vmax   <= p1_vmax;
    p2_alpha  <= p1_alpha;
    p2_sector <= p1_sector;
    p2_cq     <= CW'(p1_vmax) * CW'(p1_s2);
    p2_xf     <= p1_sector[0] ? ONE_Q - {1'b0, p1_frac} : {1'b0, p1_frac};
    // xq and mq
    p3_vmax   <= p2_vmax;
    p3_alpha  <= p2_alpha;
    p3_sector <= p2_sector;
    p3_mq     <= (CW'(p2_vmax) << FRAC_BITS) - p2_cq;
    p3_xq     <= xprod[XW-1:FRAC_BITS];
  end

  // levels and channel placement
  logic [XW-FRAC_BITS:0] msum;
  logic [7:0] top, mid, bot;
  pix_out_t   res_next;
  always_comb begin
    msum = (XW-FRAC_BITS+1)'(p3_xq) + (XW-FRAC_BITS+1)'(p3_mq);
    top  = p3_vmax;
    mid  = msum[FRAC_BITS+7:FRAC_BITS];
    bot  = p3_mq[FRAC_BITS+7:FRAC_BITS];
    res_next.alpha_out = p3_alpha;
    case (p3_sector)
      3'd0: begin res_next.red_out = top; res_next.green_out = mid; res_next.blue_out = bot; end
      3'd1: begin res_next.red_out = mid; res_next.green_out = top; res_next.blue_out = bot; end
      3'd2: begin res_next.red_out = bot; res_next.green_out = top; res_next.blue_out = mid; end
      3'd3: begin res_next.red_out = bot; res_next.green_out = mid; res_next.blue_out = top; end
      3'd4: begin res_next.red_out = mid; res_next.green_out = bot; res_next.blue_out = top; end
      default: begin
        res_next.red_out = top; res_next.green_out = bot; res_next.blue_out = mid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

// ----- tb/hsv_saturation_adjust_core_tb.sv -----
// Testbench for the HSV saturation adjust core: random and corner pixels checked against a predictor.
`timescale 1ns / 1ps

module hsv_saturation_adjust_core_tb;
  import hsv_sat_pkg::*;

  localparam int LATENCY   = FRAC_BITS + 6;
  localparam int MAX_CYCLE = 200000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  pix_in_t  item = '0;
  logic     done;
  pix_out_t result;

  hsv_saturation_adjust_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  always #1 clk = ~clk;

  pix_in_t  pixel_queue[$];
  int       gap_queue[$];
  pix_out_t expected_pixels[$];
  int       errors = 0;
  int       beats_in = 0;
  int       beats_out = 0;
  int       cycle = 0;
  int       gap_left = 0;
  logic     stim_done = 1'b0;
  logic     hold_off = 1'b0;

  // Fixed-point RGB -> HSV -> scaled saturation -> RGB.
  function automatic pix_out_t adjust_saturation(pix_in_t p);
    pix_out_t o;
    logic [31:0] r, g, b, vmax, vmin, delta, one, hue, sector, frac, sat, xf;
    logic [63:0] s2, cq, mq, xq;
    logic [31:0] top, mid, bot;
    r = 32'(p.red_in); g = 32'(p.green_in); b = 32'(p.blue_in);
    one = 32'd1 << FRAC_BITS;
    vmax = (r > g) ? r : g;
    if (b > vmax) vmax = b;
    vmin = (r < g) ? r : g;
    if (b < vmin) vmin = b;
    delta = vmax - vmin;
    hue = 0;
    if (delta > 0) begin
      if (vmax == r) begin
        if (g >= b) hue = ((g - b) << FRAC_BITS) / delta;
        else hue = 6 * one - ((b - g) << FRAC_BITS) / delta;
      end else if (vmax == g) begin
        if (b >= r) hue = 2 * one + ((b - r) << FRAC_BITS) / delta;
        else hue = 2 * one - ((r - b) << FRAC_BITS) / delta;
      end else begin
        if (r >= g) hue = 4 * one + ((r - g) << FRAC_BITS) / delta;
        else hue = 4 * one - ((g - r) << FRAC_BITS) / delta;
      end
      if (hue >= 6 * one) hue = hue - 6 * one;
    end
    sector = hue >> FRAC_BITS;
    frac = hue & (one - 1);
    sat = (vmax != 0) ? (delta << FRAC_BITS) / vmax : 0;
    s2 = (64'(sat) * 64'(p.sat_scale)) >> 8;
    if (s2 > one) s2 = one;
    cq = 64'(vmax) * s2;
    mq = (64'(vmax) << FRAC_BITS) - cq;
    xf = sector[0] ? one - frac : frac;
    xq = (cq * xf) >> FRAC_BITS;
    top = vmax;
    mid = 32'((xq + mq) >> FRAC_BITS);
    bot = 32'(mq >> FRAC_BITS);
    case (sector)
      0: begin o.red_out = top[7:0]; o.green_out = mid[7:0]; o.blue_out = bot[7:0]; end
      1: begin o.red_out = mid[7:0]; o.green_out = top[7:0]; o.blue_out = bot[7:0]; end
      2: begin o.red_out = bot[7:0]; o.green_out = top[7:0]; o.blue_out = mid[7:0]; end
      3: begin o.red_out = bot[7:0]; o.green_out = mid[7:0]; o.blue_out = top[7:0]; end
      4: begin o.red_out = mid[7:0]; o.green_out = bot[7:0]; o.blue_out = top[7:0]; end
      default: begin
        o.red_out = top[7:0]; o.green_out = bot[7:0]; o.blue_out = mid[7:0];
      end
    endcase
    o.alpha_out = p.alpha_in;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d, beat %0d: %s got %0d want %0d",
             cycle, beats_out, what, got, want);
    errors++;
  endtask

  task automatic queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [7:0] a, logic [9:0] s, int gap);
    pix_in_t p;
    p.red_in = r; p.green_in = g; p.blue_in = b; p.alpha_in = a; p.sat_scale = s;
    pixel_queue.push_back(p);
    gap_queue.push_back(gap);
  endtask

  // Driver: holds start high until the beat is taken, then waits its drawn gap.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_pixels.push_back(adjust_saturation(item));
        beats_in++;
      end
      if (start && !busy || !start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (hold_off && (expected_pixels.size() != 0 ||
                                  (start && !busy))) begin
          start <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          item <= pixel_queue.pop_front();
          gap_left <= gap_queue.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest prediction.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $display("unexpected result beat at cycle %0d", cycle);
        errors++;
      end else begin
        pix_out_t want;
        want = expected_pixels.pop_front();
        if (result.red_out !== want.red_out)
          report_mismatch("red", result.red_out, want.red_out);
        if (result.green_out !== want.green_out)
          report_mismatch("green", result.green_out, want.green_out);
        if (result.blue_out !== want.blue_out)
          report_mismatch("blue", result.blue_out, want.blue_out);
        if (result.alpha_out !== want.alpha_out)
          report_mismatch("alpha", result.alpha_out, want.alpha_out);
      end
      beats_out++;
    end
    if (cycle > MAX_CYCLE) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int kind, v, gap;
    logic [7:0] r, g, b;
    // directed: extremes, gray, black, each max channel, hue wrap, big scales
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd0, 10'd0, 0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 10'd1023, 0);
    queue_pixel(8'd128, 8'd128, 8'd128, 8'hA5, 10'd512, 0);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'h5A, 10'd1023, 0);
    queue_pixel(8'd255, 8'd0, 8'd0, 8'd1, 10'd256, 0);
    queue_pixel(8'd0, 8'd255, 8'd0, 8'd2, 10'd256, 0);
    queue_pixel(8'd0, 8'd0, 8'd255, 8'd3, 10'd256, 0);
    queue_pixel(8'd255, 8'd255, 8'd0, 8'd4, 10'd128, 0);
    queue_pixel(8'd0, 8'd255, 8'd255, 8'd5, 10'd300, 0);
    queue_pixel(8'd255, 8'd0, 8'd255, 8'd6, 10'd700, 0);
    queue_pixel(8'd255, 8'd0, 8'd1, 8'd7, 10'd256, 0);   // hue just under 360
    queue_pixel(8'd255, 8'd254, 8'd0, 8'd8, 10'd256, 0);
    queue_pixel(8'd200, 8'd100, 8'd201, 8'd9, 10'd1023, 0);
    queue_pixel(8'd10, 8'd9, 8'd200, 8'd10, 10'd1, 0);
    queue_pixel(8'd90, 8'd200, 8'd91, 8'd11, 10'd255, 0);
    queue_pixel(8'd1, 8'd0, 8'd0, 8'd12, 10'd1023, 0);
    queue_pixel(8'd170, 8'd85, 8'd42, 8'hFF, 10'd257, 3);
    queue_pixel(8'd33, 8'd66, 8'd99, 8'h80, 10'h2AA, 0);
    queue_pixel(8'd99, 8'd66, 8'd33, 8'h7F, 10'h155, 0);
    repeat (1340) begin
      kind = $urandom_range(0, 9);
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      if (kind == 0) begin
        g = r; b = r;
      end else if (kind == 1) begin
        v = $urandom_range(0, 2);
        if (v == 0) g = r; else if (v == 1) b = g; else b = r;
      end
      v = $urandom_range(0, 3);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) gap = 0;
      queue_pixel(r, g, b, 8'($urandom),
                  (v == 0) ? 10'($urandom_range(0, 1023)) :
                  (v == 1) ? 10'($urandom_range(200, 320)) :
                  (v == 2) ? 10'($urandom_range(0, 64)) : 10'($urandom_range(900, 1023)),
                  gap);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // drain pause once in the middle of the stream
    wait (beats_in >= 600);
    @(posedge clk);
    hold_off <= 1'b1;
    wait (expected_pixels.size() == 0 && !start);
    @(posedge clk);
    hold_off <= 1'b0;
    wait (pixel_queue.size() == 0 && !start);
    wait (expected_pixels.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    $display("pixels driven %0d, results checked %0d, incl. gray/black/hue-wrap/clamp cases",
             beats_in, beats_out);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
